// File: src/sr32_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sr32_pkg
// Shared widths and beat types for the pipelined signed remainder unit.
// ----------------------------------------------------------------------------
package sr32_pkg;

   // Operand width, fixed by the request and response fields
   localparam int DATA_WIDTH = 32;

   // One restoring step per pipeline stage, one step per dividend bit
   localparam int STEP_COUNT = DATA_WIDTH;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] divisor;
      logic signed [DATA_WIDTH-1:0] dividend;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] remainder;
      logic                         divide_by_zero;
   } rsp_type;

   // Working set carried down the divider pipeline
   typedef struct packed {
      logic                  negative;   // dividend was negative
      logic                  zero_div;   // divisor was zero
      logic [DATA_WIDTH-1:0] partial;    // running remainder magnitude
      logic [DATA_WIDTH-1:0] numer;      // dividend magnitude, MSB next
      logic [DATA_WIDTH-1:0] denom;      // divisor magnitude
   } stage_type;

endpackage

// File: src/sr32_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sr32_step
// One registered restoring-division step: shift in one dividend bit and
// subtract the divisor when it fits.
// ----------------------------------------------------------------------------
module sr32_step
   import sr32_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      valid_in,
   input  stage_type stage_in,
   output logic      valid_out,
   output stage_type stage_out
);

   logic              valid_ff;
   stage_type         stage_ff;
   stage_type         stage_in_next;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   diff;

   // Trial subtract of the divisor from the shifted remainder
   always_comb begin
      shifted = {stage_in.partial[DATA_WIDTH-2:0], stage_in.numer[DATA_WIDTH-1]};
      diff    = {1'b0, shifted} - {1'b0, stage_in.denom};
      stage_in_next         = stage_in;
      stage_in_next.numer   = {stage_in.numer[DATA_WIDTH-2:0], 1'b0};
      stage_in_next.partial = diff[DATA_WIDTH] ? shifted : diff[DATA_WIDTH-1:0];
   end

   // Advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      stage_ff <= stage_in_next;
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

// File: src/signed_remainder_32.sv
`timescale 1ns / 1ps
// Pipeline: a result strobes once its accepted beat has passed one entry
//   stage, one stage per dividend bit and one output stage.
// Throughput: one beat per cycle while busy is low; busy is high during reset
//   and clears once reset is released.
// Reset clears every valid bit in the pipeline; no result is lost in flight
//   otherwise, and the receiver cannot stall.
// ----------------------------------------------------------------------------
// signed_remainder_32
// Pipelined signed remainder with truncating division; zero divisor gives
// remainder zero and raises the divide-by-zero flag.
// ----------------------------------------------------------------------------
module signed_remainder_32
   import sr32_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   logic      busy_ff;
   logic      accept;
   logic      entry_valid_ff;
   stage_type entry_ff;
   stage_type entry_in;
   logic      out_valid_ff;
   rsp_type   out_ff;
   rsp_type   out_in;

   logic      chain_valid [0:STEP_COUNT];
   stage_type chain_stage [0:STEP_COUNT];

   // Hold busy high in reset and clear it once reset is released
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   // Take magnitudes and flag a zero divisor
   always_comb begin
      entry_in.negative = req_payload.dividend[DATA_WIDTH-1];
      entry_in.zero_div = (req_payload.divisor == '0);
      entry_in.partial  = '0;
      entry_in.numer    = req_payload.dividend[DATA_WIDTH-1] ?
                          (~req_payload.dividend + 1'b1) : req_payload.dividend;
      entry_in.denom    = req_payload.divisor[DATA_WIDTH-1] ?
                          (~req_payload.divisor + 1'b1) : req_payload.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain_stage[0] = entry_ff;

   // One restoring step per stage
   for (genvar i = 0; i < STEP_COUNT; i++) begin : g_step
      sr32_step u_step (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (chain_valid[i]),
         .stage_in  (chain_stage[i]),
         .valid_out (chain_valid[i+1]),
         .stage_out (chain_stage[i+1])
      );
   end

   // Restore the dividend sign, drop the remainder on a zero divisor
   always_comb begin
      out_in.divide_by_zero = chain_stage[STEP_COUNT].zero_div;
      if (chain_stage[STEP_COUNT].zero_div) begin
         out_in.remainder = '0;
      end else if (chain_stage[STEP_COUNT].negative) begin
         out_in.remainder = ~chain_stage[STEP_COUNT].partial + 1'b1;
      end else begin
         out_in.remainder = chain_stage[STEP_COUNT].partial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= chain_valid[STEP_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_strobe  = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pipelined signed remainder unit. A queue of
// operand pairs feeds a negedge driver. A posedge monitor predicts each
// accepted beat's remainder and flag, then checks strobed results in order.
// ----------------------------------------------------------------------------
module tb
   import sr32_pkg::*;
();

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 225;
   localparam int LIMIT_CYCLES = 200_000;

   localparam logic signed [DATA_WIDTH-1:0] MOST_NEGATIVE = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] MOST_POSITIVE = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MINUS_ONE     = '1;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   req_type pending_beats[$];
   rsp_type expected_remainders[$];
   int      mismatch_count = 0;
   int      send_idle_pct  = 32;
   logic    beat_taken     = 1'b0;

   signed_remainder_32 uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Free-running clock
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Remainder with quotient truncated toward zero; sign follows the dividend
   function automatic rsp_type truncated_remainder(req_type beat);
      logic [DATA_WIDTH-1:0] divisor_mag;
      logic [DATA_WIDTH-1:0] dividend_mag;
      logic [DATA_WIDTH-1:0] rem_mag;
      rsp_type               result;
      divisor_mag  = beat.divisor[DATA_WIDTH-1] ? ~beat.divisor + 1'b1 : beat.divisor;
      dividend_mag = beat.dividend[DATA_WIDTH-1] ? ~beat.dividend + 1'b1 : beat.dividend;
      if (divisor_mag == '0) begin
         result.remainder      = '0;
         result.divide_by_zero = 1'b1;
      end else begin
         rem_mag = dividend_mag % divisor_mag;
         result.remainder      = beat.dividend[DATA_WIDTH-1] ? ~rem_mag + 1'b1 : rem_mag;
         result.divide_by_zero = 1'b0;
      end
      return result;
   endfunction

   // Operand mix: full range, small values, corners, powers of two, near extremes, shifted random magnitudes
   function automatic logic signed [DATA_WIDTH-1:0] random_operand();
      logic signed [DATA_WIDTH-1:0] value;
      case ($urandom_range(0, 7))
         0, 1, 2: value = $urandom;
         3: value = int'($urandom_range(0, 32)) - 16;
         4: begin
            case ($urandom_range(0, 5))
               0: value = 0;
               1: value = 1;
               2: value = MINUS_ONE;
               3: value = MOST_NEGATIVE;
               4: value = MOST_POSITIVE;
               default: value = MOST_NEGATIVE + 1;
            endcase
         end
         5: begin
            value = 1 << $urandom_range(0, DATA_WIDTH - 1);
            if ($urandom_range(0, 1) == 1) value = -value;
         end
         6: begin
            if ($urandom_range(0, 1) == 1) value = MOST_POSITIVE - $urandom_range(0, 7);
            else value = MOST_NEGATIVE + $urandom_range(0, 7);
         end
         default: begin
            value = $urandom >> $urandom_range(0, DATA_WIDTH - 1);
            if ($urandom_range(0, 1) == 1) value = -value;
         end
      endcase
      return value;
   endfunction

   task automatic queue_pair(input logic signed [DATA_WIDTH-1:0] divisor,
                             input logic signed [DATA_WIDTH-1:0] dividend);
      req_type beat;
      beat.divisor  = divisor;
      beat.dividend = dividend;
      pending_beats.push_back(beat);
   endtask

   task automatic queue_random_pairs(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) queue_pair('0, random_operand());
         else queue_pair(random_operand(), random_operand());
      end
   endtask

   // Hold off until every queued beat is sent and every result has strobed
   task automatic wait_drained();
      while (pending_beats.size() != 0 || start || expected_remainders.size() != 0)
         @(negedge clock);
   endtask

   // Drive beats at the falling edge; advance only after the current beat is taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_payload <= pending_beats.pop_front();
            start       <= 1'b1;
         end else begin
            req_payload <= {$urandom, $urandom};
            start       <= 1'b0;
         end
      end
   end

   // Check strobed results against the oldest prediction, then record new beats
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         beat_taken <= start && !busy;
         if (rsp_strobe) begin
            if (expected_remainders.size() == 0) begin
               $display("%0t: unexpected result, actual remainder %h flag %b",
                        $time, rsp_payload.remainder, rsp_payload.divide_by_zero);
               mismatch_count++;
            end else begin
               want = expected_remainders.pop_front();
               if (rsp_payload.remainder !== want.remainder) begin
                  $display("%0t: remainder mismatch, expected %h actual %h",
                           $time, want.remainder, rsp_payload.remainder);
                  mismatch_count++;
               end
               if (rsp_payload.divide_by_zero !== want.divide_by_zero) begin
                  $display("%0t: divide_by_zero mismatch, expected %b actual %b",
                           $time, want.divide_by_zero, rsp_payload.divide_by_zero);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) expected_remainders.push_back(truncated_remainder(req_payload));
      end
   end

   // Stimulus sequence
   initial begin
      // Corners: zero divisor, most negative over minus one, extremes, sign mix
      queue_pair('0, '0);
      queue_pair('0, MOST_POSITIVE);
      queue_pair('0, MOST_NEGATIVE);
      queue_pair(MINUS_ONE, MOST_NEGATIVE);
      queue_pair(MINUS_ONE, MOST_POSITIVE);
      queue_pair(1, MOST_NEGATIVE);
      queue_pair(2, MOST_NEGATIVE);
      queue_pair(3, MOST_NEGATIVE);
      queue_pair(MOST_NEGATIVE, MOST_NEGATIVE);
      queue_pair(MOST_NEGATIVE, MOST_POSITIVE);
      queue_pair(MOST_POSITIVE, MOST_NEGATIVE);
      queue_pair(MOST_POSITIVE, MOST_POSITIVE);
      queue_pair(MOST_POSITIVE, MOST_POSITIVE - 1);
      queue_pair(MOST_NEGATIVE, '0);
      queue_pair(7, 23);
      queue_pair(7, -23);
      queue_pair(-7, 23);
      queue_pair(-7, -23);
      queue_pair(5, 3);
      queue_pair(-5, -3);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender idles about a third of the time
      send_idle_pct = 32;
      queue_random_pairs(PHASE_ITEMS);
      wait_drained();

      // Sender idles more than half the time
      send_idle_pct = 55;
      queue_random_pairs(PHASE_ITEMS);
      wait_drained();

      // Back-to-back beats
      send_idle_pct = 0;
      queue_random_pairs(PHASE_ITEMS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_remainders.size() == 0) begin
         $display("** signed_remainder_32: PASSED **");
      end else begin
         $display("** signed_remainder_32: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(2 * CLOCK_HALF * LIMIT_CYCLES);
      $display("** signed_remainder_32: FAILED **");
      $finish;
   end

endmodule
